@@ src/mds_pkg.sv @@
//------------------------------------------------------------------------------
// mds_pkg
// Shared types, constants and operation codes of the map signature engine.
//------------------------------------------------------------------------------
`default_nettype none
package mds_pkg;

  localparam int MAX_VERTICES    = 256;
  localparam int MAX_DEGREE      = 8;
  localparam int MAX_TYPES       = 16;
  localparam int SIGNATURE_DEPTH = 2048;
  localparam int LABEL_BITS      = 16;

  typedef enum logic [2:0] {
    OP_LOAD_VERTEX = 3'd0,
    OP_LOAD_EDGE   = 3'd1,
    OP_LOAD_LABEL  = 3'd2,
    OP_START       = 3'd3,
    OP_READ        = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_BAD_SLOT = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  vertex;
    logic [2:0]  slot;
    logic [7:0]  other_vertex;
    logic [2:0]  other_slot;
    logic [3:0]  degree;
    logic [3:0]  vertex_type;
    logic [15:0] label;
    logic [10:0] position;
  } in_item_t;

  typedef struct packed {
    logic [10:0] rank;
    logic [15:0] edge_label;
    logic [10:0] length;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_ROOT,
    S_PUSH2,
    S_POP,
    S_FETCH,
    S_VISIT,
    S_NEIGH,
    S_STORE,
    S_RDWAIT,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

@@ src/mds_ram.sv @@
//------------------------------------------------------------------------------
// mds_ram
// Generic single write port RAM with registered read.
//------------------------------------------------------------------------------
`default_nettype none
module mds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/map_dfs_signature_engine.sv @@
//------------------------------------------------------------------------------
// map_dfs_signature_engine
// Holds a combinatorial map and builds a depth-first signature by a stack walk.
//------------------------------------------------------------------------------
//  channel  direction  payload
//  in_*     input      in_item_t  (operation, map load, start, read)
//  out_*    output     out_item_t (rank, edge_label, length, status)
//
//  A load is written when its result is taken; a read waits on the
//  registered signature store. A start clears the rank store (one entry a
//  cycle), pushes the root pair, and then for each signature element pops
//  the stack, fetches the vertex and its rank, pushes the neighbours on a
//  first visit and stores the element; the stack, vertex and rank memories
//  have registered reads. One item is worked at a time; in_ready is low
//  until the result has been taken. Reset is synchronous, active high.
//------------------------------------------------------------------------------
`default_nettype none
module map_dfs_signature_engine #(
  parameter int MAX_VERTICES    = mds_pkg::MAX_VERTICES,
  parameter int MAX_DEGREE      = mds_pkg::MAX_DEGREE,
  parameter int MAX_TYPES       = mds_pkg::MAX_TYPES,
  parameter int SIGNATURE_DEPTH = mds_pkg::SIGNATURE_DEPTH,
  parameter int LABEL_BITS      = mds_pkg::LABEL_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire mds_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mds_pkg::out_item_t       out_data
);

  import mds_pkg::*;

  localparam int VB  = $clog2(MAX_VERTICES);
  localparam int DB  = $clog2(MAX_DEGREE);
  localparam int TB  = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
  localparam int SB  = $clog2(SIGNATURE_DEPTH);
  localparam int GB  = $clog2(MAX_DEGREE + 1);
  localparam int HEW = VB + DB;
  localparam int VTW = GB + TB;
  localparam int SGW = SB + LABEL_BITS;

  state_t state, state_next;

  in_item_t          item;
  logic [SB:0]       stack_top;
  logic [SB-1:0]     sig_len;
  logic [1:0]        status;
  logic [VB-1:0]     clr_cnt;
  logic [VB-1:0]     cv;
  logic [DB-1:0]     ce;
  logic [GB-1:0]     cdeg;
  logic [TB-1:0]     ctype;
  logic [GB-1:0]     nidx;
  logic [GB-1:0]     npush;
  logic [GB-1:0]     ncnt;
  logic [SB-1:0]     crank;
  logic              full;
  logic              first;

  // rank store
  logic              rk_we;
  logic [VB-1:0]     rk_waddr, rk_raddr;
  logic [SB-1:0]     rk_wdata, rk_rdata;
  // vertex table
  logic              vt_we;
  logic [VB-1:0]     vt_raddr;
  logic [VTW-1:0]    vt_wdata, vt_rdata;
  // half-edge table
  logic              he_we;
  logic [HEW-1:0]    he_waddr, he_raddr;
  logic [HEW-1:0]    he_wdata, he_rdata;
  // label table
  logic              lb_we;
  logic [TB+DB-1:0]  lb_waddr, lb_raddr;
  logic [LABEL_BITS-1:0] lb_rdata;
  // walk stack
  logic              sk_we;
  logic [SB-1:0]     sk_waddr, sk_raddr;
  logic [HEW-1:0]    sk_wdata, sk_rdata;
  // signature store
  logic              sg_we;
  logic [SB-1:0]     sg_waddr, sg_raddr;
  logic [SGW-1:0]    sg_wdata, sg_rdata;

  logic [VB-1:0]     in_v, in_ov;
  logic [DB-1:0]     in_s, in_os;
  logic              slot_ok, type_ok;
  logic [GB-1:0]     in_deg;
  logic [GB-1:0]     vdeg;
  logic [TB-1:0]     vtype;
  logic [DB-1:0]     nslot;
  logic              read_ok;
  logic              push_now;

  assign in_v    = VB'(item.vertex);
  assign in_ov   = VB'(item.other_vertex);
  assign in_s    = DB'(item.slot);
  assign in_os   = DB'(item.other_slot);
  assign slot_ok = 32'(item.slot) < MAX_DEGREE;
  assign type_ok = 32'(item.vertex_type) < MAX_TYPES;
  assign in_deg  = (32'(item.degree) > MAX_DEGREE) ? GB'(MAX_DEGREE) : GB'(item.degree);
  assign vdeg    = vt_rdata[VTW-1:TB];
  assign vtype   = vt_rdata[TB-1:0];
  assign nslot   = DB'(nidx);
  assign read_ok = (item.position != '0) && (32'(item.position) <= 32'(sig_len));

  // The neighbour loop reads ahead: ncnt counts issued reads, and each push uses the data of an earlier read.
  assign push_now = (state == S_NEIGH) && (ncnt != '0) && !full &&
                    32'(stack_top) < SIGNATURE_DEPTH;

  mds_ram #(.WIDTH(SB), .DEPTH(MAX_VERTICES)) u_rank (
    .clk, .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata), .raddr(rk_raddr),
    .rdata(rk_rdata));
  mds_ram #(.WIDTH(VTW), .DEPTH(MAX_VERTICES)) u_vtx (
    .clk, .we(vt_we), .waddr(in_v), .wdata(vt_wdata), .raddr(vt_raddr),
    .rdata(vt_rdata));
  mds_ram #(.WIDTH(HEW), .DEPTH(MAX_VERTICES*MAX_DEGREE)) u_he (
    .clk, .we(he_we), .waddr(he_waddr), .wdata(he_wdata), .raddr(he_raddr),
    .rdata(he_rdata));
  mds_ram #(.WIDTH(LABEL_BITS), .DEPTH((1<<TB)*MAX_DEGREE)) u_lab (
    .clk, .we(lb_we), .waddr(lb_waddr), .wdata(item.label[LABEL_BITS-1:0]),
    .raddr(lb_raddr), .rdata(lb_rdata));
  mds_ram #(.WIDTH(HEW), .DEPTH(SIGNATURE_DEPTH)) u_stack (
    .clk, .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata), .raddr(sk_raddr),
    .rdata(sk_rdata));
  mds_ram #(.WIDTH(SGW), .DEPTH(SIGNATURE_DEPTH)) u_sig (
    .clk, .we(sg_we), .waddr(sg_waddr), .wdata(sg_wdata), .raddr(sg_raddr),
    .rdata(sg_rdata));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) begin
        case (op_t'(in_valid ? in_data.operation : 3'd0))
          OP_START: state_next = S_CLEAR;
          OP_READ:  state_next = S_RDWAIT;
          default:  state_next = S_DONE;
        endcase
      end
      S_CLEAR:  if (clr_cnt == VB'(MAX_VERTICES - 1)) state_next = S_ROOT;
      S_ROOT:   state_next = ({1'b0, in_s} >= {1'b0, vdeg}) ? S_DONE : S_PUSH2;
      S_PUSH2:  state_next = S_POP;
      S_POP: begin
        if (stack_top == '0) state_next = S_DONE;
        else if (32'(sig_len) >= SIGNATURE_DEPTH - 1) state_next = S_DONE;
        else state_next = S_FETCH;
      end
      S_FETCH:  state_next = S_VISIT;
      S_VISIT:  state_next = (rk_rdata == '0) ? S_NEIGH : S_STORE;
      S_NEIGH: begin
        if (ncnt == npush || full) state_next = S_STORE;
      end
      S_STORE:  state_next = full ? S_DONE : S_POP;
      S_RDWAIT: state_next = S_DONE;
      S_DONE:   if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      sig_len <= '0;
      stack_top <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: if (in_valid && op_t'(in_data.operation) == OP_START) begin
          sig_len   <= '0;
          stack_top <= '0;
        end
        S_ROOT:  stack_top <= ({1'b0, in_s} >= {1'b0, vdeg}) ? '0 : (SB+1)'(1);
        S_PUSH2: stack_top <= (SB+1)'(2);
        S_POP:   if (stack_top != '0 && 32'(sig_len) < SIGNATURE_DEPTH - 1)
          stack_top <= stack_top - 1'b1;
        S_NEIGH: if (push_now)
          stack_top <= stack_top + 1'b1;
        S_STORE: sig_len <= sig_len + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        item    <= in_data;
        clr_cnt <= '0;
        status  <= ST_OK;
      end
      S_CLEAR: clr_cnt <= clr_cnt + 1'b1;
      S_ROOT:  if ({1'b0, in_s} >= {1'b0, vdeg}) status <= ST_BAD_SLOT;
      S_POP:   if (stack_top != '0 && 32'(sig_len) >= SIGNATURE_DEPTH - 1)
        status <= ST_OVERFLOW;
      S_FETCH: begin
        cv <= sk_rdata[HEW-1:DB];
        ce <= sk_rdata[DB-1:0];
      end
      S_VISIT: begin
        cdeg  <= vdeg;
        ctype <= vtype;
        first <= (rk_rdata == '0);
        crank <= (rk_rdata == '0) ? sig_len + 1'b1 : rk_rdata;
        full  <= 1'b0;
        ncnt  <= '0;
        if (GB'(ce) < vdeg) begin
          npush <= vdeg - 1'b1;
          nidx  <= (GB'(ce) + 1'b1 == vdeg) ? '0 : GB'(ce) + 1'b1;
        end else begin
          npush <= vdeg;
          nidx  <= '0;
        end
      end
      S_NEIGH: begin
        // ncnt 0 issues the first table read; later steps push its data
        if (ncnt != '0 && !full && 32'(stack_top) >= SIGNATURE_DEPTH) full <= 1'b1;
        if (!(ncnt == npush || full)) begin
          nidx <= (nidx + 1'b1 == cdeg) ? '0 : nidx + 1'b1;
          ncnt <= ncnt + 1'b1;
        end
      end
      S_STORE: if (full) status <= ST_OVERFLOW;
      default: ;
    endcase
  end

  // memory control
  always_comb begin
    rk_we = 1'b0; rk_waddr = clr_cnt; rk_wdata = '0; rk_raddr = '0;
    vt_we = 1'b0; vt_wdata = {in_deg, TB'(item.vertex_type)}; vt_raddr = in_v;
    he_we = 1'b0; he_waddr = {in_v, in_s}; he_wdata = {in_ov, in_os};
    he_raddr = {in_v, in_s};
    lb_we = 1'b0; lb_waddr = {TB'(item.vertex_type), in_s}; lb_raddr = {ctype, ce};
    sk_we = 1'b0; sk_waddr = SB'(stack_top); sk_wdata = he_rdata;
    sk_raddr = SB'(stack_top - 1'b1);
    sg_we = 1'b0; sg_waddr = SB'(sig_len + 1'b1); sg_wdata = {crank, lb_rdata};
    sg_raddr = SB'(item.position);
    case (state)
      S_IDLE: begin
        vt_raddr = VB'(in_data.vertex);
        he_raddr = {VB'(in_data.vertex), DB'(in_data.slot)};
      end
      S_CLEAR: rk_we = 1'b1;
      S_DONE: if (out_ready && op_t'(item.operation) != OP_START) begin
        vt_we = op_t'(item.operation) == OP_LOAD_VERTEX;
        he_we = op_t'(item.operation) == OP_LOAD_EDGE && slot_ok;
        lb_we = op_t'(item.operation) == OP_LOAD_LABEL && slot_ok && type_ok;
      end
      S_ROOT: begin
        sk_we = ({1'b0, in_s} < {1'b0, vdeg});
        sk_waddr = '0;
        sk_wdata = {in_v, in_s};
      end
      S_PUSH2: begin
        sk_we = 1'b1;
        sk_waddr = SB'(1);
        sk_wdata = he_rdata;
      end
      S_POP: begin
        vt_raddr = '0;
      end
      S_FETCH: begin
        vt_raddr = sk_rdata[HEW-1:DB];
        rk_raddr = sk_rdata[HEW-1:DB];
      end
      S_VISIT: begin
        lb_raddr = {vtype, ce};
      end
      S_NEIGH: begin
        he_raddr = {cv, nslot};
        sk_we    = push_now;
      end
      S_STORE: begin
        sg_we = 1'b1;
        rk_we = first;
        rk_waddr = cv;
        rk_wdata = crank;
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state == S_IDLE);
    out_valid = (state == S_DONE);
    out_data  = '0;
    out_data.length = 11'(sig_len);
    out_data.status = status;
    if (op_t'(item.operation) == OP_READ && read_ok) begin
      out_data.rank       = 11'(sg_rdata[SGW-1:LABEL_BITS]);
      out_data.edge_label = 16'(sg_rdata[LABEL_BITS-1:0]);
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("in_ready high while result pending");
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    32'(stack_top) <= SIGNATURE_DEPTH) else $error("stack pointer beyond depth");
  a_len_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !out_ready) |=> $stable(sig_len))
    else $error("length changed while result pending");
`endif

endmodule
`default_nettype wire

@@ test/tb_map_dfs_signature_engine.sv @@
//------------------------------------------------------------------------------
// tb_map_dfs_signature_engine
// Self-checking bench for the map signature engine. Loads random small maps
// with random content, runs stack walks from random roots and reads the
// signatures back, mixed with stray loads and unused operation codes. A
// scoreboard predicts every answer; both handshakes idle at random.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_map_dfs_signature_engine;
  import mds_pkg::*;

  localparam int IDLE_LIMIT = 100000;
  localparam int N_ITEMS    = 1350;

  class signature_scoreboard;
    logic [3:0]  deg_tab [MAX_VERTICES];
    logic [3:0]  type_tab [MAX_VERTICES];
    bit          vtx_wr [MAX_VERTICES];
    logic [7:0]  he_vtx [MAX_VERTICES*MAX_DEGREE];
    logic [2:0]  he_slot [MAX_VERTICES*MAX_DEGREE];
    bit          he_wr [MAX_VERTICES*MAX_DEGREE];
    logic [15:0] lbl_tab [MAX_TYPES*MAX_DEGREE];
    bit          lbl_wr [MAX_TYPES*MAX_DEGREE];
    logic [10:0] sig_rank [SIGNATURE_DEPTH];
    logic [15:0] sig_lbl [SIGNATURE_DEPTH];
    int          sig_len;
    out_item_t   pending [$];
    int          mismatches;

    function new();
      foreach (deg_tab[i]) begin
        deg_tab[i] = 0; type_tab[i] = 0; vtx_wr[i] = 0;
      end
      foreach (he_vtx[i]) begin
        he_vtx[i] = 0; he_slot[i] = 0; he_wr[i] = 0;
      end
      foreach (lbl_tab[i]) begin
        lbl_tab[i] = 0; lbl_wr[i] = 0;
      end
      sig_len = 0;
      mismatches = 0;
    endfunction

    // returns 1 when the walk touches only written table entries
    function bit walk(input int root, input int rs, input bit commit,
                      output int len, output status_t st);
      int rk [MAX_VERTICES];
      int sv [SIGNATURE_DEPTH];
      int ss [SIGNATURE_DEPTH];
      int top, cv, ce, d, lim, idx;
      bit full, ok;
      ok = 1; len = 0; top = 0; full = 0; st = ST_OK;
      foreach (rk[i]) rk[i] = 0;
      if (!vtx_wr[root]) return 0;
      if (rs >= deg_tab[root]) begin
        st = ST_BAD_SLOT;
        if (commit) sig_len = 0;
        return 1;
      end
      if (!he_wr[root*MAX_DEGREE+rs]) ok = 0;
      sv[0] = root; ss[0] = rs;
      sv[1] = he_vtx[root*MAX_DEGREE+rs]; ss[1] = he_slot[root*MAX_DEGREE+rs];
      top = 2;
      while (top > 0) begin
        if (len >= SIGNATURE_DEPTH - 1) begin
          st = ST_OVERFLOW;
          break;
        end
        top--;
        cv = sv[top]; ce = ss[top];
        if (!vtx_wr[cv]) ok = 0;
        if (rk[cv] == 0) begin
          rk[cv] = len + 1;
          d = deg_tab[cv];
          lim = ce < d ? ce : d;
          for (int i = ce + 1; i < d && !full; i++) begin
            idx = cv*MAX_DEGREE + i;
            if (top >= SIGNATURE_DEPTH) begin
              full = 1;
              break;
            end
            if (!he_wr[idx]) ok = 0;
            sv[top] = he_vtx[idx]; ss[top] = he_slot[idx];
            top++;
          end
          for (int i = 0; i < lim && !full; i++) begin
            idx = cv*MAX_DEGREE + i;
            if (top >= SIGNATURE_DEPTH) begin
              full = 1;
              break;
            end
            if (!he_wr[idx]) ok = 0;
            sv[top] = he_vtx[idx]; ss[top] = he_slot[idx];
            top++;
          end
        end
        len++;
        idx = type_tab[cv]*MAX_DEGREE + ce;
        if (!lbl_wr[idx]) ok = 0;
        if (commit) begin
          sig_rank[len] = 11'(rk[cv]);
          sig_lbl[len] = lbl_tab[idx];
        end
        if (full) begin
          st = ST_OVERFLOW;
          break;
        end
      end
      if (commit) sig_len = len;
      return ok;
    endfunction

    function void note_input(in_item_t it);
      out_item_t exp_item;
      int len, pos;
      status_t st;
      bit ok;
      exp_item = '0;
      case (op_t'(it.operation))
        OP_LOAD_VERTEX: begin
          deg_tab[it.vertex] = it.degree > MAX_DEGREE ? 4'(MAX_DEGREE) : it.degree;
          type_tab[it.vertex] = it.vertex_type;
          vtx_wr[it.vertex] = 1;
        end
        OP_LOAD_EDGE: begin
          he_vtx[it.vertex*MAX_DEGREE+it.slot] = it.other_vertex;
          he_slot[it.vertex*MAX_DEGREE+it.slot] = it.other_slot;
          he_wr[it.vertex*MAX_DEGREE+it.slot] = 1;
        end
        OP_LOAD_LABEL: begin
          lbl_tab[it.vertex_type*MAX_DEGREE+it.slot] = it.label;
          lbl_wr[it.vertex_type*MAX_DEGREE+it.slot] = 1;
        end
        OP_START: begin
          ok = walk(it.vertex, it.slot, 1, len, st);
          exp_item.status = st;
        end
        OP_READ: begin
          pos = it.position;
          if (pos >= 1 && pos <= sig_len) begin
            exp_item.rank = sig_rank[pos];
            exp_item.edge_label = sig_lbl[pos];
          end
        end
        default: ;
      endcase
      exp_item.length = 11'(sig_len);
      pending.push_back(exp_item);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      e = pending.pop_front();
      if (got.rank !== e.rank || got.edge_label !== e.edge_label ||
          got.length !== e.length || got.status !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("exp rank %0d lbl %h len %0d st %0d / got rank %0d lbl %h len %0d st %0d",
                   e.rank, e.edge_label, e.length, e.status,
                   got.rank, got.edge_label, got.length, got.status);
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst = 1;
  logic      in_valid = 0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 0;
  out_item_t out_data;

  signature_scoreboard sb = new();
  int  sent = 0;
  int  idle_cycles = 0;
  bit  hold_out = 0;

  map_dfs_signature_engine DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = $urandom_range(0, 8);
      if (hold_out) begin
        gap = 400;
        hold_out = 0;
      end
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  function automatic in_item_t rand_item(op_t op);
    in_item_t it;
    it = in_item_t'(60'({$urandom, $urandom}));
    it.operation = op;
    return it;
  endfunction

  task automatic send(in_item_t it);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    sent++;
  endtask

  task automatic send_reads();
    in_item_t it;
    repeat ($urandom_range(3, 8)) begin
      it = rand_item(OP_READ);
      case ($urandom_range(0, 5))
        0: it.position = 11'($urandom_range(0, 2047));
        1: it.position = 11'(sb.sig_len + $urandom_range(1, 3));
        default: it.position = 11'($urandom_range(0, sb.sig_len));
      endcase
      send(it);
    end
  endtask

  task automatic send_map_and_walk();
    in_item_t it;
    int ids [$];
    int n, v, d, len;
    status_t st;
    n = $urandom_range(2, 10);
    repeat (n) ids.push_back($urandom_range(0, MAX_VERTICES - 1));
    foreach (ids[k]) begin
      it = rand_item(OP_LOAD_VERTEX);
      it.vertex = 8'(ids[k]);
      it.degree = $urandom_range(0, 9) == 0 ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(1, 8));
      if ($urandom_range(0, 2) != 0) it.vertex_type = 4'($urandom_range(0, 3));
      send(it);
    end
    foreach (ids[k]) begin
      d = sb.deg_tab[ids[k]];
      for (int s = 0; s < d; s++) begin
        it = rand_item(OP_LOAD_EDGE);
        it.vertex = 8'(ids[k]);
        it.slot = 3'(s);
        it.other_vertex = 8'(ids[$urandom_range(0, n - 1)]);
        send(it);
      end
    end
    foreach (ids[k]) begin
      v = sb.type_tab[ids[k]];
      for (int s = 0; s < MAX_DEGREE; s++) begin
        if (!sb.lbl_wr[v*MAX_DEGREE+s]) begin
          it = rand_item(OP_LOAD_LABEL);
          it.vertex_type = 4'(v);
          it.slot = 3'(s);
          send(it);
        end
      end
    end
    for (int tries = 0; tries < 4; tries++) begin
      it = rand_item(OP_START);
      it.vertex = 8'(ids[$urandom_range(0, n - 1)]);
      if ($urandom_range(0, 5) != 0)
        it.slot = 3'($urandom_range(0, sb.deg_tab[it.vertex] - 1));
      if (sb.walk(it.vertex, it.slot, 0, len, st)) begin
        send(it);
        send_reads();
        break;
      end
    end
  endtask

  task automatic send_noise();
    in_item_t it;
    int len;
    status_t st;
    case ($urandom_range(0, 5))
      0: it = rand_item(op_t'(3'(OP_READ) + 3'($urandom_range(1, 3))));
      1: it = rand_item(OP_LOAD_VERTEX);
      2: it = rand_item(OP_LOAD_EDGE);
      3: it = rand_item(OP_LOAD_LABEL);
      4: it = rand_item(OP_READ);
      default: begin
        it = rand_item(OP_START);
        // only walks over written entries
        if (!sb.walk(it.vertex, it.slot, 0, len, st)) it.operation = OP_READ;
      end
    endcase
    send(it);
  endtask

  initial begin
    in_item_t it;
    bit held, drained;
    held = 0;
    drained = 0;
    repeat (10) @(posedge clk);
    rst <= 0;

    // directed: saturated degree, self loops, label extremes, bad slots
    it = rand_item(OP_READ); it.position = 11'd1; send(it);
    it = rand_item(OP_LOAD_VERTEX); it.vertex = 8'd255; it.degree = 4'd15;
    it.vertex_type = 4'd15; send(it);
    for (int s = 0; s < MAX_DEGREE; s++) begin
      it = rand_item(OP_LOAD_EDGE); it.vertex = 8'd255; it.slot = 3'(s);
      it.other_vertex = 8'd255; it.other_slot = 3'(7 - s); send(it);
    end
    for (int s = 0; s < MAX_DEGREE; s++) begin
      it = rand_item(OP_LOAD_LABEL); it.vertex_type = 4'd15; it.slot = 3'(s);
      it.label = s[0] ? 16'hFFFF : 16'h0000; send(it);
    end
    it = rand_item(OP_START); it.vertex = 8'd255; it.slot = 3'd3; send(it);
    it = rand_item(OP_READ); it.position = 11'd0; send(it);
    it = rand_item(OP_READ); it.position = 11'd2; send(it);
    it = rand_item(OP_READ); it.position = 11'd2047; send(it);
    for (int k = 1; k <= 3; k++) begin
      it = rand_item(op_t'(3'(OP_READ) + 3'(k))); send(it);
    end
    it = rand_item(OP_LOAD_VERTEX); it.vertex = 8'd0; it.degree = 4'd0; send(it);
    it = rand_item(OP_START); it.vertex = 8'd0; it.slot = 3'd0; send(it);

    while (sent < N_ITEMS) begin
      if (sent > 500 && !held) begin
        hold_out = 1;
        held = 1;
      end
      if (sent > 900 && !drained) begin
        drained = 1;
        @(negedge clk);
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_map_and_walk();
    end
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
